>>> rtl/ppg_pulse_beat_detector_macros.svh
// Assertion macros for the pulse beat detector.
`ifndef PPG_PULSE_BEAT_DETECTOR_MACROS_SVH
`define PPG_PULSE_BEAT_DETECTOR_MACROS_SVH

// Check a consequence in the same cycle; the module supplies clk and rst.
`define PPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define PPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ppgbd_pkg.sv
// Types, constants and saturation helpers for the pulse beat detector.
`timescale 1ns / 1ps

package ppgbd_pkg;

  // Field widths and fixed point format
  localparam int FRAC_BITS = 8;
  localparam int RAW_W     = 18;
  localparam int ALPHA_W   = 15;
  localparam int THR_W     = 16;
  localparam int ACC_W     = 40;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 36;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 4;

  // Digit-serial datapath sizing
  localparam int DIGIT_W     = 4;
  localparam int MUL_DIGITS  = (ALPHA_W + DIGIT_W - 1) / DIGIT_W;
  localparam int ALPHA_PAD_W = MUL_DIGITS * DIGIT_W;
  localparam int MDC_W       = $clog2(MUL_DIGITS);
  localparam int PART_W      = ACC_W + DIGIT_W + 1;
  localparam int PROD_W      = ACC_W + ALPHA_PAD_W;
  localparam int ROUND_SH    = ALPHA_W;
  localparam int DIV_DIGITS  = SUM_W / DIGIT_W;
  localparam int DDC_W       = $clog2(DIV_DIGITS);
  localparam int SAT_IN_W    = 48;
  localparam int IP_W        = VAL_W - FRAC_BITS;
  localparam int CMP_W       = (THR_W + FRAC_BITS >= VAL_W) ? THR_W + FRAC_BITS + 1 : VAL_W + 1;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 15'd29491;
  localparam logic [THR_W-1:0]   MIN_RST   = 16'd150;
  localparam logic [THR_W-1:0]   MAX_RST   = 16'd2000;

  // Register indexes (paddr word address)
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_MIN   = 2'd1;
  localparam logic [1:0] REG_MAX   = 2'd2;

  // Detector state codes seen on the result word
  localparam logic [1:0] DET_IDLE = 2'd0;
  localparam logic [1:0] DET_UP   = 2'd1;
  localparam logic [1:0] DET_DOWN = 2'd2;

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_MUL   = 10'b00_0000_0010,
    ST_ROUND = 10'b00_0000_0100,
    ST_DIFF  = 10'b00_0000_1000,
    ST_SUM   = 10'b00_0001_0000,
    ST_ABS   = 10'b00_0010_0000,
    ST_DIV   = 10'b00_0100_0000,
    ST_SIGN  = 10'b00_1000_0000,
    ST_FILT  = 10'b01_0000_0000,
    ST_TRACK = 10'b10_0000_0000
  } fsm_t;

  // Peak tracker states
  typedef enum logic [2:0] {
    TRK_IDLE = 3'b001,
    TRK_UP   = 3'b010,
    TRK_DOWN = 3'b100
  } trk_t;

  // Clamp a wide signed value to the signal width
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-VAL_W:0] top;
    top = v[SAT_IN_W-1:VAL_W-1];
    if (top == '0 || top == '1) return v[VAL_W-1:0];
    else if (v[SAT_IN_W-1]) return {1'b1, {(VAL_W-1){1'b0}}};
    else return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  // Clamp a wide signed value to the DC accumulator width
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-ACC_W:0] top;
    top = v[SAT_IN_W-1:ACC_W-1];
    if (top == '0 || top == '1) return v[ACC_W-1:0];
    else if (v[SAT_IN_W-1]) return {1'b1, {(ACC_W-1){1'b0}}};
    else return {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

endpackage

>>> rtl/ppg_pulse_beat_detector.sv
// Pulse beat detector: DC removal, mean-difference filter and peak tracker.
`timescale 1ns / 1ps
`include "ppg_pulse_beat_detector_macros.svh"

// One raw infrared sample goes in per input word and one result word comes
// out. Each word passes in order through the accept step, the DC feedback
// multiplier (alpha taken four bits per cycle), rounding, differencing,
// window update and magnitude, the radix-16 divider that forms the window
// mean, sign restoration of the mean, and filter output and peak tracking;
// the next sample is accepted only after the tracker step has finished.
// The result sits in an output register, so the next sample is taken while
// the previous result still waits; the tracking cycle holds only if that
// result has not been taken by then. The window needs no clearing pass after
// reset: entries not yet written since reset read as zero via the fill count.
// Configuration registers (APB, word addresses): 0 dc_alpha (Q0.15),
// 1 min_threshold, 2 max_threshold; write them only while the block is idle.
module ppg_pulse_beat_detector
  import ppgbd_pkg::*;
#(
  parameter int WINDOW_LEN = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [CFG_W-1:0]         pwdata,
  output logic [CFG_W-1:0]         prdata,
  output logic                     pready,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RAW_W-1:0]         raw_sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  filtered_value,
  output logic                     beat_pulse,
  output logic [VAL_W-1:0]         beat_count,
  output logic [THR_W-1:0]         peak_level,
  output logic [1:0]               detector_state
);

  localparam int POS_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int VW    = CNT_W + DIGIT_W;
  localparam int PR_W  = PROD_W + 1;
  localparam int SH_W  = PR_W - ROUND_SH;
  localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(WINDOW_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
  localparam logic [PR_W-1:0]  RND_HALF = PR_W'(1) << (ROUND_SH - 1);
  localparam logic [MDC_W-1:0] MUL_LAST = MDC_W'(MUL_DIGITS - 1);
  localparam logic [DDC_W-1:0] DIV_LAST = DDC_W'(DIV_DIGITS - 1);

  // sequencer and configuration
  fsm_t               state;
  logic [ALPHA_W-1:0] dc_alpha;
  logic [THR_W-1:0]   min_threshold;
  logic [THR_W-1:0]   max_threshold;

  // model state
  logic signed [ACC_W-1:0] dc_acc;
  logic signed [VAL_W-1:0] ring [WINDOW_LEN];
  logic [POS_W-1:0]        wr_pos;
  logic signed [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0]        fill_cnt;
  trk_t                    trk;
  logic signed [VAL_W-1:0] prev_val;
  logic [THR_W-1:0]        last_peak;
  logic [VAL_W-1:0]        peak_total;

  // per-word datapath
  logic [RAW_W-1:0]        raw_hold;
  logic [ALPHA_PAD_W-1:0]  alpha_sr;
  logic signed [PROD_W-1:0] prod_acc;
  logic [MDC_W-1:0]        mul_cnt;
  logic signed [ACC_W-1:0] w_new;
  logic signed [VAL_W-1:0] old_val;
  logic signed [VAL_W-1:0] d_val;
  logic [CNT_W-1:0]        den;
  logic                    neg_q;
  logic [SUM_W-1:0]        div_sr;
  logic [SUM_W-1:0]        quot;
  logic [CNT_W-1:0]        rem;
  logic [DDC_W-1:0]        div_step;
  logic signed [SUM_W:0]   avg;
  logic signed [VAL_W-1:0] f_val;

  // combinational intermediates
  logic [DIGIT_W-1:0]         mul_digit;
  logic signed [PART_W-1:0]   partial;
  logic signed [PROD_W-1:0]   prod_next;
  logic [PR_W-1:0]            prod_r;
  logic [SH_W-1:0]            prod_sh;
  logic signed [SAT_IN_W-1:0] w_sum;
  logic signed [SAT_IN_W-1:0] d_sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W:0]             quot_ext;
  logic signed [SUM_W:0]      avg_next;
  logic signed [SAT_IN_W-1:0] f_sum;
  logic [VW-1:0]              div_val;
  logic [DIGIT_W-1:0]         q_digit;
  logic [VW-1:0]              rem_full;
  logic [POS_W-1:0]           pos_next;
  logic [CNT_W-1:0]           fill_next;
  logic                       track_fire;

  // tracker intermediates
  logic signed [CMP_W-1:0] f_cmp;
  logic signed [CMP_W-1:0] fmin_cmp;
  logic signed [CMP_W-1:0] fmax_cmp;
  logic [IP_W-1:0]         ip;
  logic [THR_W-1:0]        peak_clamp;
  trk_t                    trk_next;
  logic signed [VAL_W-1:0] prev_next;
  logic [THR_W-1:0]        peak_next;
  logic [VAL_W-1:0]        total_next;
  logic                    beat_next;

  assign pready     = 1'b1;
  assign in_ready   = (state == ST_IDLE) && !rst;
  assign track_fire = (state == ST_TRACK) && (!out_valid || out_ready);
  assign beat_count = peak_total;
  assign peak_level = last_peak;

  // read back configuration
  always_comb begin
    unique case (paddr[3:2])
      REG_ALPHA: prdata = CFG_W'(dc_alpha);
      REG_MIN:   prdata = CFG_W'(min_threshold);
      REG_MAX:   prdata = CFG_W'(max_threshold);
      default:   prdata = '0;
    endcase
  end

  // map tracker state onto the result code
  always_comb begin
    unique case (trk)
      TRK_UP:   detector_state = DET_UP;
      TRK_DOWN: detector_state = DET_DOWN;
      default:  detector_state = DET_IDLE;
    endcase
  end

  // multiply step: shift the product and add one alpha digit times dc_acc
  assign mul_digit = alpha_sr[ALPHA_PAD_W-1 -: DIGIT_W];
  assign partial   = PART_W'(dc_acc) * PART_W'($signed({1'b0, mul_digit}));
  assign prod_next = (prod_acc <<< DIGIT_W)
                   + {{(PROD_W-PART_W){partial[PART_W-1]}}, partial};

  // round the Q.15 product and add the scaled sample
  assign prod_r  = {prod_acc[PROD_W-1], prod_acc} + RND_HALF;
  assign prod_sh = prod_r[PR_W-1:ROUND_SH];
  assign w_sum   = {{(SAT_IN_W-SH_W){prod_sh[SH_W-1]}}, prod_sh}
                 + {{(SAT_IN_W-RAW_W-FRAC_BITS){1'b0}}, raw_hold, {FRAC_BITS{1'b0}}};

  // DC-removed difference
  assign d_sum = {{(SAT_IN_W-ACC_W){w_new[ACC_W-1]}}, w_new}
               - {{(SAT_IN_W-ACC_W){dc_acc[ACC_W-1]}}, dc_acc};

  // window sum, position and fill
  assign sum_next  = win_sum
                   - {{(SUM_W-VAL_W){old_val[VAL_W-1]}}, old_val}
                   + {{(SUM_W-VAL_W){d_val[VAL_W-1]}}, d_val};
  assign pos_next  = (wr_pos == POS_LAST) ? '0 : wr_pos + 1'b1;
  assign fill_next = (fill_cnt == WIN_FULL) ? fill_cnt : fill_cnt + 1'b1;
  assign sum_mag   = win_sum[SUM_W-1] ? (~win_sum + 1'b1) : win_sum;

  // radix-16 divider digit: largest q with q*den not above the partial value
  assign div_val = {rem, div_sr[SUM_W-1 -: DIGIT_W]};
  always_comb begin
    q_digit = '0;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      if (VW'(k) * VW'(den) <= div_val) q_digit = DIGIT_W'(k);
    end
  end
  assign rem_full = div_val - VW'(q_digit) * VW'(den);

  // signed mean and filter output
  assign quot_ext = {1'b0, quot};
  assign avg_next = neg_q ? (~quot_ext + 1'b1) : quot_ext;
  assign f_sum    = {{(SAT_IN_W-SUM_W-1){avg[SUM_W]}}, avg}
                  - {{(SAT_IN_W-VAL_W){d_val[VAL_W-1]}}, d_val};

  // peak tracker next state
  assign f_cmp    = {{(CMP_W-VAL_W){f_val[VAL_W-1]}}, f_val};
  assign fmin_cmp = {{(CMP_W-THR_W-FRAC_BITS){1'b0}}, min_threshold, {FRAC_BITS{1'b0}}};
  assign fmax_cmp = {{(CMP_W-THR_W-FRAC_BITS){1'b0}}, max_threshold, {FRAC_BITS{1'b0}}};
  assign ip       = f_val[VAL_W-1:FRAC_BITS];
  assign peak_clamp = ip[IP_W-1] ? '0 : ((|ip[IP_W-2:THR_W]) ? '1 : ip[THR_W-1:0]);

  always_comb begin
    trk_next   = trk;
    prev_next  = f_val;
    peak_next  = last_peak;
    total_next = peak_total;
    beat_next  = 1'b0;
    priority if (f_cmp > fmax_cmp) begin
      trk_next  = TRK_IDLE;
      prev_next = '0;
      peak_next = '0;
    end else begin
      unique case (trk)
        TRK_UP: begin
          if (f_val > prev_val) begin
            peak_next = peak_clamp;
          end else begin
            total_next = peak_total + 1'b1;
            beat_next  = 1'b1;
            trk_next   = TRK_DOWN;
            prev_next  = prev_val;
          end
        end
        TRK_DOWN: begin
          if (f_cmp < fmin_cmp) trk_next = TRK_IDLE;
        end
        default: begin
          trk_next = (f_cmp >= fmin_cmp) ? TRK_UP : TRK_IDLE;
        end
      endcase
    end
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      dc_alpha      <= ALPHA_RST;
      min_threshold <= MIN_RST;
      max_threshold <= MAX_RST;
      dc_acc        <= '0;
      wr_pos        <= '0;
      win_sum       <= '0;
      fill_cnt      <= '0;
      trk           <= TRK_IDLE;
      prev_val      <= '0;
      last_peak     <= '0;
      peak_total    <= '0;
    end else begin
      // take configuration writes
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_ALPHA: dc_alpha      <= pwdata[ALPHA_W-1:0];
          REG_MIN:   min_threshold <= pwdata[THR_W-1:0];
          REG_MAX:   max_threshold <= pwdata[THR_W-1:0];
          default: ;
        endcase
      end

      // drop the result once taken, raise it when the tracker finishes
      if (track_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      // advance the sequencer
      unique case (state)
        ST_IDLE:  if (in_valid && in_ready) state <= ST_MUL;
        ST_MUL:   if (mul_cnt == MUL_LAST) state <= ST_ROUND;
        ST_ROUND: state <= ST_DIFF;
        ST_DIFF: begin
          dc_acc <= w_new;
          state  <= ST_SUM;
        end
        ST_SUM: begin
          win_sum  <= sum_next;
          wr_pos   <= pos_next;
          fill_cnt <= fill_next;
          state    <= ST_ABS;
        end
        ST_ABS:   state <= ST_DIV;
        ST_DIV:   if (div_step == DIV_LAST) state <= ST_SIGN;
        ST_SIGN:  state <= ST_FILT;
        ST_FILT:  state <= ST_TRACK;
        ST_TRACK: begin
          if (track_fire) begin
            trk        <= trk_next;
            prev_val   <= prev_next;
            last_peak  <= peak_next;
            peak_total <= total_next;
            state      <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // per-word datapath and window storage
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        raw_hold <= raw_sample;
        alpha_sr <= ALPHA_PAD_W'(dc_alpha);
        prod_acc <= '0;
        mul_cnt  <= '0;
      end
      ST_MUL: begin
        prod_acc <= prod_next;
        alpha_sr <= alpha_sr << DIGIT_W;
        mul_cnt  <= mul_cnt + 1'b1;
      end
      ST_ROUND: begin
        w_new   <= sat_acc(w_sum);
        old_val <= (fill_cnt == WIN_FULL) ? ring[wr_pos] : '0;
      end
      ST_DIFF: d_val <= sat_val(d_sum);
      ST_SUM: begin
        ring[wr_pos] <= d_val;
        den          <= fill_next;
      end
      ST_ABS: begin
        neg_q    <= win_sum[SUM_W-1];
        div_sr   <= sum_mag;
        quot     <= '0;
        rem      <= '0;
        div_step <= '0;
      end
      ST_DIV: begin
        rem      <= rem_full[CNT_W-1:0];
        quot     <= {quot[SUM_W-DIGIT_W-1:0], q_digit};
        div_sr   <= div_sr << DIGIT_W;
        div_step <= div_step + 1'b1;
      end
      ST_SIGN: avg <= avg_next;
      ST_FILT: f_val <= sat_val(f_sum);
      ST_TRACK: begin
        if (track_fire) begin
          filtered_value <= f_val;
          beat_pulse     <= beat_next;
        end
      end
      default: ;
    endcase
  end

  // window position tracks the fill count until the window is full
  `PPG_ASSERT_NOW(a_pos_follows_fill, fill_cnt < WIN_FULL, wr_pos == POS_W'(fill_cnt),
                  "window position out of step with fill count")

  // a finished tracking cycle presents a result and frees the sequencer
  `PPG_ASSERT_NEXT(a_track_done, track_fire, (state == ST_IDLE) && out_valid,
                   "tracking cycle did not complete")

  // an accepted sample starts the multiplier
  `PPG_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == ST_MUL,
                   "accepted sample did not start")

  // the beat count moves only with a presented beat
  `PPG_ASSERT_NOW(a_count_with_beat, peak_total != $past(peak_total),
                  out_valid && beat_pulse, "beat count changed without a beat")

endmodule
